// ===== hdl/hpas_pkg.sv =====
// Shared types and constants for the Hall period averaging speed block.
package hpas_pkg;

    // Field widths
    localparam int SCALE_W  = 24;
    localparam int PERIOD_W = 16;
    localparam int READ_W   = 20;
    localparam int OVF_BITS = 16;
    localparam int SUM_OUT_W = 23;

    // Defaults and limits
    localparam int RING_DEPTH_DEF = 8;
    localparam logic [SCALE_W-1:0] RESET_SCALE = 24'd65536;
    localparam logic [63:0] HOUR_FACTOR = 64'd360000000;
    localparam logic [3:0] STOP_OVERFLOWS = 4'd8;
    localparam logic signed [3:0] DIR_LIMIT = 4'sd5;
    localparam logic [30:0] SPEED_MAX = 31'h7FFF_FFFF;

    // Request codes
    localparam logic REQ_EDGE     = 1'b0;
    localparam logic REQ_OVERFLOW = 1'b1;

    // Input word
    typedef struct packed {
        logic                req_type;
        logic [PERIOD_W-1:0] period;
        logic                dir_pin;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic signed [31:0]   speed;
        logic signed [3:0]    direction_level;
        logic [SUM_OUT_W-1:0] period_sum;
    } t_out_word;

    // Ring write request
    typedef struct packed {
        logic              push;
        logic [READ_W-1:0] reading;
    } t_push;

endpackage

// ===== hdl/hpas_addsub.sv =====
// Shared adder/subtractor used by the multiply and divide sequences.
module hpas_addsub #(
    parameter int W = hpas_pkg::READ_W
) (
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic         i_sub,
    output logic [W-1:0] o_y,
    output logic         o_co
);

    logic [W-1:0] w_b;
    logic [W:0]   w_res;

    // Invert and add one for subtract; carry out means a >= b
    assign w_b   = i_sub ? ~i_b : i_b;
    assign w_res = {1'b0, i_a} + {1'b0, w_b} + (W+1)'(i_sub);
    assign o_y   = w_res[W-1:0];
    assign o_co  = w_res[W];

endmodule

// ===== hdl/hpas_ring.sv =====
// Ring of period readings with a running sum and per-entry valid bits.
module hpas_ring #(
    parameter int RING_DEPTH = hpas_pkg::RING_DEPTH_DEF,
    parameter int SW = hpas_pkg::READ_W + $clog2(RING_DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  hpas_pkg::t_push i_push,
    output logic [SW-1:0]   o_sum
);

    localparam int PTW = $clog2(RING_DEPTH);

    logic [hpas_pkg::READ_W-1:0] r_mem [RING_DEPTH];
    logic [hpas_pkg::READ_W-1:0] r_rd_data;
    logic                        r_rd_vld;
    logic [RING_DEPTH-1:0]       r_valid;
    logic [PTW-1:0]              r_ptr;
    logic [SW-1:0]               r_sum;

    logic [hpas_pkg::READ_W-1:0] w_old;
    logic [SW-1:0]               n_sum;
    logic [PTW-1:0]              n_ptr;

    // Write at the pointer; read the entry the next push replaces
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_ptr] <= i_push.reading;
        end
        r_rd_data <= r_mem[r_ptr];
    end

    // Entry never written reads as zero
    assign w_old = r_rd_vld ? r_rd_data : '0;
    assign n_sum = r_sum + SW'(i_push.reading) - SW'(w_old);
    assign n_ptr = (r_ptr == PTW'(RING_DEPTH - 1)) ? '0 : r_ptr + PTW'(1);

    // Advance pointer and sum on a push
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_ptr    <= '0;
            r_sum    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_valid[r_ptr];
            if (i_push.push) begin
                r_valid[r_ptr] <= 1'b1;
                r_ptr          <= n_ptr;
                r_sum          <= n_sum;
            end
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== hdl/hall_period_average_speed_top.sv =====
// Hall period averaging tachometer: event sequencer, multiply/divide datapath.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one event word:
// an edge with a captured period and the direction pin, or a timer overflow.
// Every event yields exactly one output word (o_out_valid / i_out_stall /
// o_out_data) with the speed, the direction counter and the period sum.
// The speed is wheel_scale * 360000000 * RING_DEPTH / (sum * 65536), built by
// a shift-add multiply (24 steps) and a restoring divide (one quotient bit
// per step) that share one adder/subtractor.
// Each event passes through an update state, a prepare state, the multiply
// steps, the divide steps and a done state that writes the output word once
// the register is free. With a zero period sum the speed is 0 and the
// multiply and divide are skipped. The next event can be taken in the
// cycle after the word is written.
// The block takes no event while one is in progress. A finished word waits in
// the output register while the receiver stalls; the next event is accepted
// meanwhile, and its word waits for the register to free.
// Reset (synchronous, active low) empties the ring, sets the direction to +5,
// clears the overflow count and sets wheel_scale to 65536. The user must write
// wheel_scale (i_cfg_valid / o_cfg_ready / i_cfg_data) only while idle; unchecked.
module hall_period_average_speed_top #(
    parameter int RING_DEPTH = hpas_pkg::RING_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  hpas_pkg::t_in_word           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output hpas_pkg::t_out_word          o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [hpas_pkg::SCALE_W-1:0] i_cfg_data
);

    localparam int SW = hpas_pkg::READ_W + $clog2(RING_DEPTH);
    localparam logic [63:0] K64 = hpas_pkg::HOUR_FACTOR * 64'(RING_DEPTH);
    localparam int KW = $clog2(K64 + 64'd1);
    localparam logic [KW-1:0] K = KW'(K64);
    localparam int PW = hpas_pkg::SCALE_W + KW;
    localparam int DW = PW - hpas_pkg::OVF_BITS;
    localparam int UW = (PW > SW + 1) ? PW : SW + 1;
    localparam int CW = $clog2(DW + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]                  r_state, n_state;
    logic [CW-1:0]               r_cnt, n_cnt;
    logic [PW-1:0]               r_acc, n_acc;
    logic [SW-1:0]               r_rem, n_rem;
    logic [hpas_pkg::SCALE_W-1:0] r_mplr, n_mplr;
    logic                        r_zero, n_zero;
    hpas_pkg::t_in_word          r_item, n_item;
    logic [3:0]                  r_ovf, n_ovf;
    logic signed [3:0]           r_dir, n_dir;
    logic [hpas_pkg::SCALE_W-1:0] r_scale;
    logic                        r_out_valid, n_out_valid;
    hpas_pkg::t_out_word         r_out, n_out;

    hpas_pkg::t_push             w_push;
    logic [SW-1:0]               w_sum;
    logic [UW-1:0]               w_a, w_b, w_y;
    logic                        w_sub, w_co;
    logic                        w_in_acc;
    logic                        w_out_free;
    logic [3:0]                  w_ovf_inc;
    logic signed [3:0]           w_dstep;
    logic [SW:0]                 w_rem_sh;
    logic [30:0]                 w_mag;
    logic [SW+hpas_pkg::SUM_OUT_W-1:0] w_sum_ext;

    hpas_ring #(
        .RING_DEPTH(RING_DEPTH),
        .SW        (SW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .o_sum  (w_sum)
    );

    hpas_addsub #(
        .W(UW)
    ) u_addsub (
        .i_a  (w_a),
        .i_b  (w_b),
        .i_sub(w_sub),
        .o_y  (w_y),
        .o_co (w_co)
    );

    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_ovf_inc  = r_ovf + 4'd1;
    assign w_rem_sh   = {r_rem, r_acc[DW-1]};

    // Feed the shared unit: shift-add while multiplying, trial subtract while dividing
    always_comb begin
        w_sub = (r_state == S_DIV);
        if (w_sub) begin
            w_a = UW'(w_rem_sh);
            w_b = UW'(w_sum);
        end else begin
            w_a = UW'({r_acc, 1'b0});
            w_b = r_mplr[hpas_pkg::SCALE_W-1] ? UW'(K) : '0;
        end
    end

    // Build the ring push on an edge or on the stop reading
    always_comb begin
        w_push.push    = 1'b0;
        w_push.reading = {r_ovf, r_item.period};
        if (r_state == S_UPD) begin
            if (r_item.req_type == hpas_pkg::REQ_EDGE) begin
                w_push.push = 1'b1;
            end else if (w_ovf_inc >= hpas_pkg::STOP_OVERFLOWS) begin
                w_push.push    = 1'b1;
                w_push.reading = {w_ovf_inc, hpas_pkg::OVF_BITS'(0)};
            end
        end
    end

    // Step direction, skip zero, saturate
    always_comb begin
        w_dstep = r_dir + (r_item.dir_pin ? 4'sd1 : -4'sd1);
        if (w_dstep == 4'sd0) begin
            w_dstep = r_item.dir_pin ? 4'sd1 : -4'sd1;
        end
        if (w_dstep > hpas_pkg::DIR_LIMIT) begin
            w_dstep = hpas_pkg::DIR_LIMIT;
        end
        if (w_dstep < -hpas_pkg::DIR_LIMIT) begin
            w_dstep = -hpas_pkg::DIR_LIMIT;
        end
    end

    // Saturate the quotient magnitude
    always_comb begin
        if (r_zero) begin
            w_mag = '0;
        end else if (|r_acc[DW-1:31]) begin
            w_mag = hpas_pkg::SPEED_MAX;
        end else begin
            w_mag = r_acc[30:0];
        end
    end

    assign w_sum_ext = {{hpas_pkg::SUM_OUT_W{1'b0}}, w_sum};

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_rem       = r_rem;
        n_mplr      = r_mplr;
        n_zero      = r_zero;
        n_item      = r_item;
        n_ovf       = r_ovf;
        n_dir       = r_dir;
        n_out_valid = r_out_valid;
        n_out       = r_out;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_item  = i_in_data;
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                if (r_item.req_type == hpas_pkg::REQ_EDGE) begin
                    n_ovf = '0;
                    n_dir = w_dstep;
                end else if (w_ovf_inc >= hpas_pkg::STOP_OVERFLOWS) begin
                    n_ovf = '0;
                end else begin
                    n_ovf = w_ovf_inc;
                end
                n_state = S_PREP;
            end
            S_PREP: begin
                n_zero  = (w_sum == '0);
                n_acc   = '0;
                n_mplr  = r_scale;
                n_cnt   = '0;
                n_state = (w_sum == '0) ? S_DONE : S_MUL;
            end
            S_MUL: begin
                n_acc  = w_y[PW-1:0];
                n_mplr = {r_mplr[hpas_pkg::SCALE_W-2:0], 1'b0};
                n_cnt  = r_cnt + CW'(1);
                if (r_cnt == CW'(hpas_pkg::SCALE_W - 1)) begin
                    n_acc   = w_y[PW-1:0] >> hpas_pkg::OVF_BITS;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = w_co ? w_y[SW-1:0] : w_rem_sh[SW-1:0];
                n_acc = PW'({r_acc[DW-2:0], w_co});
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(DW - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out.speed           = r_dir[3] ? -$signed({1'b0, w_mag})
                                                     : $signed({1'b0, w_mag});
                    n_out.direction_level = r_dir;
                    n_out.period_sum      = w_sum_ext[hpas_pkg::SUM_OUT_W-1:0];
                    n_out_valid           = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovf       <= '0;
            r_dir       <= hpas_pkg::DIR_LIMIT;
            r_out_valid <= 1'b0;
            r_scale     <= hpas_pkg::RESET_SCALE;
        end else begin
            r_state     <= n_state;
            r_ovf       <= n_ovf;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_scale <= i_cfg_data;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_rem  <= n_rem;
        r_mplr <= n_mplr;
        r_zero <= n_zero;
        r_item <= n_item;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule
